// File: hdl/utmpm_pkg.sv
// upper-triangular matrix power mod prime: shared types and constants
// no dependencies
`timescale 1ns / 1ps

package utmpm_pkg;

  localparam logic [29:0] PRIME    = 30'd998244353;
  localparam logic [31:0] PRIME_X1 = 32'd998244353;
  localparam logic [31:0] PRIME_X2 = 32'd1996488706;
  // barrett factor floor(2^60 / p)
  localparam logic [30:0] BARRETT_MU = 31'(64'h1000_0000_0000_0000 / 64'd998244353);

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_COMPUTE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  localparam logic CFG_EXPONENT = 1'b0;
  localparam logic CFG_DIM      = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [29:0] entry_value;
  } item_t;

  typedef struct packed {
    logic [29:0] read_value;
    logic        in_triangle;
  } result_t;

endpackage

// File: hdl/upper_triangular_matrix_power_mod_top.sv
// upper-triangular matrix power mod prime, square-and-multiply on one
// pipelined barrett multiply-accumulate unit; uses utmpm_pkg
//
// channel   direction  handshake            payload
// item      in         item_valid/ready     utmpm_pkg::item_t
// result    out        result_valid/ready   utmpm_pkg::result_t
// cfg       in         cfg_we               cfg_index, cfg_data
//
// write and ignored transactions go from idle straight to the done state, reads by way of a read-wait state
// compute: per product n(n+1)(n+2)/6 macs at one a cycle, then a pipeline drain
// and a copy sweep over the triangle; a squaring for every exponent bit and a multiply
// for every set bit, after an initial setup sweep
// after reset all (2**clog2(MAX_DIM))**2 base store entries are cleared before an item is taken
// a waiting result stalls only the final step of the next transaction
`timescale 1ns / 1ps

module upper_triangular_matrix_power_mod_top #(
  parameter int MAX_DIM = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  utmpm_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output utmpm_pkg::result_t result,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CW    = (DW > 5) ? DW : 5;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_RDWAIT = 4'd2;
  localparam logic [3:0] ST_SWEEP  = 4'd3;
  localparam logic [3:0] ST_SWEND  = 4'd4;
  localparam logic [3:0] ST_BIT    = 4'd5;
  localparam logic [3:0] ST_MUL    = 4'd6;
  localparam logic [3:0] ST_DRAIN  = 4'd7;
  localparam logic [3:0] ST_DONE   = 4'd8;

  localparam logic [1:0] KIND_INIT = 2'd0;
  localparam logic [1:0] KIND_TO_P = 2'd1;
  localparam logic [1:0] KIND_TO_S = 2'd2;

  typedef struct packed {
    logic          v;
    logic          first;
    logic          last;
    logic [AW-1:0] dst;
  } tag_t;

  logic [29:0] mem_b  [DEPTH];
  logic [29:0] mem_p  [DEPTH];
  logic [29:0] mem_s0 [DEPTH];
  logic [29:0] mem_s1 [DEPTH];
  logic [29:0] mem_t  [DEPTH];

  logic [3:0]    state;
  logic [1:0]    kind;
  logic          mul_sq;
  logic [AW-1:0] clr_addr;
  logic [IW-1:0] ci, cj, ck, nm1;
  logic [30:0]   exponent;
  logic [4:0]    dim;
  logic [30:0]   exponent_shift;
  logic [CW-1:0] comp_dim;
  logic          rd_ok;
  logic [29:0]   res_val;
  logic          res_flag;

  logic [29:0] b_rd, p_rd, s0_rd, s1_rd, t_rd;
  logic          sw_v;
  logic          sw_diag;
  logic [AW-1:0] sw_addr;

  tag_t        t1, t2, t3, t4, t5, t6;
  logic [59:0] prod, prod_d, prod_e;
  logic [61:0] bq;
  logic [60:0] qp;
  logic [31:0] rem;
  logic [29:0] rr;
  logic [29:0] acc;

  logic [CW-1:0] dim_ext, eff_dim;
  logic          in_tri;
  logic [AW-1:0] item_addr, p_ra, s0_ra, s1_ra, bt_ra;
  logic          accept;
  logic          b_we;
  logic [29:0]   b_wval;
  logic [29:0]   xd, yd;
  logic [29:0]   acc_base;
  logic [30:0]   acc_sum;
  logic [29:0]   acc_new;
  logic [30:0]   q;

  always_comb begin
    dim_ext = CW'(dim);
    if (dim_ext == '0) begin
      eff_dim = CW'(1);
    end else if (dim_ext > CW'(MAX_DIM)) begin
      eff_dim = CW'(MAX_DIM);
    end else begin
      eff_dim = dim_ext;
    end
  end

  assign in_tri    = (item.row <= item.col) && (CW'(item.col) < eff_dim);
  assign item_addr = {IW'(item.row), IW'(item.col)};
  assign item_ready = (state == ST_IDLE);
  assign accept    = item_valid && item_ready;
  assign b_we      = accept && (item.mode == utmpm_pkg::MODE_WRITE) && in_tri;
  assign b_wval    = (item.entry_value >= utmpm_pkg::PRIME) ?
                     item.entry_value - utmpm_pkg::PRIME : item.entry_value;

  assign p_ra  = (state == ST_MUL) ? {ci, ck} : item_addr;
  assign s0_ra = mul_sq ? {ci, ck} : {ck, cj};
  assign s1_ra = {ck, cj};
  assign bt_ra = {ci, cj};

  // memories
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mem_b[clr_addr] <= '0;
    end else if (b_we) begin
      mem_b[item_addr] <= b_wval;
    end
    b_rd <= mem_b[bt_ra];
  end

  always_ff @(posedge clk) begin
    if (sw_v && (kind == KIND_INIT)) begin
      mem_p[sw_addr] <= sw_diag ? 30'd1 : 30'd0;
    end else if (sw_v && (kind == KIND_TO_P)) begin
      mem_p[sw_addr] <= t_rd;
    end
    p_rd <= mem_p[p_ra];
  end

  always_ff @(posedge clk) begin
    if (sw_v && (kind == KIND_INIT)) begin
      mem_s0[sw_addr] <= b_rd;
      mem_s1[sw_addr] <= b_rd;
    end else if (sw_v && (kind == KIND_TO_S)) begin
      mem_s0[sw_addr] <= t_rd;
      mem_s1[sw_addr] <= t_rd;
    end
    s0_rd <= mem_s0[s0_ra];
    s1_rd <= mem_s1[s1_ra];
  end

  always_ff @(posedge clk) begin
    if (t6.v && t6.last) begin
      mem_t[t6.dst] <= acc_new;
    end
    t_rd <= mem_t[bt_ra];
  end

  // multiply, barrett reduction and accumulate
  assign xd = mul_sq ? s0_rd : p_rd;
  assign yd = mul_sq ? s1_rd : s0_rd;
  assign q  = bq[61:31];

  always_comb begin
    acc_base = t6.first ? 30'd0 : acc;
    acc_sum  = {1'b0, acc_base} + {1'b0, rr};
    acc_new  = (acc_sum >= {1'b0, utmpm_pkg::PRIME}) ?
               30'(acc_sum - {1'b0, utmpm_pkg::PRIME}) : acc_sum[29:0];
  end

  always_ff @(posedge clk) begin
    prod   <= 60'(xd) * 60'(yd);
    bq     <= 62'(prod[59:29]) * 62'(utmpm_pkg::BARRETT_MU);
    prod_d <= prod;
    qp     <= 61'(q) * 61'(utmpm_pkg::PRIME);
    prod_e <= prod_d;
    rem    <= 32'({1'b0, prod_e} - qp);
    if (rem >= utmpm_pkg::PRIME_X2) begin
      rr <= 30'(rem - utmpm_pkg::PRIME_X2);
    end else if (rem >= utmpm_pkg::PRIME_X1) begin
      rr <= 30'(rem - utmpm_pkg::PRIME_X1);
    end else begin
      rr <= rem[29:0];
    end
    if (t6.v) begin
      acc <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
      t4 <= '0;
      t5 <= '0;
      t6 <= '0;
    end else begin
      t1.v     <= (state == ST_MUL);
      t1.first <= (ck == ci);
      t1.last  <= (ck == cj);
      t1.dst   <= {ci, cj};
      t2 <= t1;
      t3 <= t2;
      t4 <= t3;
      t5 <= t4;
      t6 <= t5;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= 31'd1;
      dim      <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        utmpm_pkg::CFG_EXPONENT: exponent <= cfg_data;
        utmpm_pkg::CFG_DIM:      dim <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      sw_v           <= 1'b0;
      exponent_shift <= '0;
      comp_dim       <= '0;
      kind           <= KIND_INIT;
      mul_sq         <= 1'b0;
    end else begin
      sw_v <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == {AW{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_val  <= '0;
            rd_ok    <= in_tri && (CW'(item.col) < comp_dim);
            case (item.mode)
              utmpm_pkg::MODE_WRITE: begin
                res_flag <= in_tri;
                state    <= ST_DONE;
              end
              utmpm_pkg::MODE_READ: begin
                res_flag <= in_tri;
                state    <= ST_RDWAIT;
              end
              utmpm_pkg::MODE_COMPUTE: begin
                res_flag       <= 1'b0;
                comp_dim       <= eff_dim;
                nm1            <= IW'(eff_dim - CW'(1));
                exponent_shift <= exponent;
                kind           <= KIND_INIT;
                ci             <= '0;
                cj             <= '0;
                state          <= ST_SWEEP;
              end
              default: begin
                res_flag <= 1'b0;
                state    <= ST_DONE;
              end
            endcase
          end
        end
        ST_RDWAIT: begin
          res_val <= rd_ok ? p_rd : 30'd0;
          state   <= ST_DONE;
        end
        ST_SWEEP: begin
          sw_v    <= 1'b1;
          sw_addr <= {ci, cj};
          sw_diag <= (ci == cj);
          if (cj == nm1) begin
            if (ci == nm1) begin
              state <= ST_SWEND;
            end else begin
              ci <= ci + IW'(1);
              cj <= ci + IW'(1);
            end
          end else begin
            cj <= cj + IW'(1);
          end
        end
        ST_SWEND: begin
          ci <= '0;
          cj <= '0;
          ck <= '0;
          case (kind)
            KIND_TO_P: begin
              mul_sq <= 1'b1;
              state  <= ST_MUL;
            end
            KIND_TO_S: begin
              exponent_shift <= exponent_shift >> 1;
              state          <= ST_BIT;
            end
            default: state <= ST_BIT;
          endcase
        end
        ST_BIT: begin
          ci <= '0;
          cj <= '0;
          ck <= '0;
          if (exponent_shift == '0) begin
            state <= ST_DONE;
          end else begin
            mul_sq <= ~exponent_shift[0];
            state  <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (ck == cj) begin
            if (cj == nm1) begin
              if (ci == nm1) begin
                state <= ST_DRAIN;
              end else begin
                ci <= ci + IW'(1);
                cj <= ci + IW'(1);
                ck <= ci + IW'(1);
              end
            end else begin
              cj <= cj + IW'(1);
              ck <= ci;
            end
          end else begin
            ck <= ck + IW'(1);
          end
        end
        ST_DRAIN: begin
          if (!(t1.v || t2.v || t3.v || t4.v || t5.v || t6.v)) begin
            kind  <= mul_sq ? KIND_TO_S : KIND_TO_P;
            ci    <= '0;
            cj    <= '0;
            state <= ST_SWEEP;
          end
        end
        ST_DONE: begin
          if (!result_valid || result_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == ST_DONE) && (!result_valid || result_ready)) begin
      result_valid       <= 1'b1;
      result.read_value  <= res_val;
      result.in_triangle <= res_flag;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// File: test/testbench.sv
// self-checking testbench for upper_triangular_matrix_power_mod_top
// predicts every result transaction with an in-bench matrix power model; uses utmpm_pkg
`timescale 1ns / 1ps

module testbench;

  localparam int DIM = 16;
  localparam longint unsigned P = 64'd998244353;

  typedef bit [29:0] mat_t [DIM*DIM];

  logic clk, rst;
  logic item_valid, item_ready, result_valid, result_ready;
  utmpm_pkg::item_t item;
  utmpm_pkg::result_t result;
  logic cfg_we, cfg_index;
  logic [30:0] cfg_data;

  upper_triangular_matrix_power_mod_top #(.MAX_DIM(DIM)) dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // prediction state
  mat_t base_m, power_m;
  bit [30:0] exp_reg;
  bit [4:0] dim_reg;
  utmpm_pkg::result_t expected_q[$];

  int errors = 0;
  int n_writes = 0, n_computes = 0, n_reads = 0, n_results = 0;
  bit idle_on = 1;
  int hold_req = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4 * 3000000);
    $display("upper_triangular_matrix_power_mod_top regression: fail");
    $finish;
  end

  function automatic int unsigned used_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > DIM) return DIM;
    return dim_reg;
  endfunction

  function automatic mat_t tri_product(mat_t a, mat_t b, int unsigned n);
    mat_t c;
    longint unsigned acc;
    foreach (c[i]) c[i] = '0;
    for (int i = 0; i < n; i++)
      for (int j = i; j < n; j++) begin
        acc = 0;
        for (int k = i; k <= j; k++)
          acc = (acc + (longint'(a[i*DIM+k]) * longint'(b[k*DIM+j])) % P) % P;
        c[i*DIM+j] = acc[29:0];
      end
    return c;
  endfunction

  function automatic void raise_power();
    mat_t sq;
    bit [30:0] e;
    int unsigned n;
    n = used_dim();
    foreach (power_m[i]) power_m[i] = '0;
    for (int i = 0; i < n; i++) power_m[i*DIM+i] = 30'd1;
    sq = base_m;
    e = exp_reg;
    while (e != 0) begin
      if (e[0]) power_m = tri_product(power_m, sq, n);
      sq = tri_product(sq, sq, n);
      e = e >> 1;
    end
  endfunction

  function automatic utmpm_pkg::result_t predict(utmpm_pkg::item_t it);
    utmpm_pkg::result_t r;
    bit in_tri;
    in_tri = (it.row <= it.col) && (it.col < used_dim());
    r = '0;
    case (it.mode)
      utmpm_pkg::MODE_WRITE: begin
        r.in_triangle = in_tri;
        if (in_tri) base_m[it.row*DIM+it.col] = 30'(longint'(it.entry_value) % P);
        n_writes++;
      end
      utmpm_pkg::MODE_COMPUTE: begin
        raise_power();
        n_computes++;
      end
      utmpm_pkg::MODE_READ: begin
        r.in_triangle = in_tri;
        if (in_tri) r.read_value = power_m[it.row*DIM+it.col];
        n_reads++;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %0d: %s got %0d expected %0d", errors, what, got, want);
  endtask

  // result checker
  initial begin
    utmpm_pkg::result_t want;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          report("unexpected result transaction", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (result.read_value !== want.read_value)
            report("read_value", result.read_value, want.read_value);
          if (result.in_triangle !== want.in_triangle)
            report("in_triangle", result.in_triangle, want.in_triangle);
        end
      end
    end
  end

  // receiver
  initial begin
    int n;
    result_ready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    result_ready <= 1'b1;
    forever begin
      if (hold_req > 0) begin
        result_ready <= 1'b0;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
        result_ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = idle_on ? $urandom_range(0, 10) : 0;
        if (n > 0) begin
          result_ready <= 1'b0;
          repeat (n) @(posedge clk);
          result_ready <= 1'b1;
        end
        do @(posedge clk);
        while (!(result_valid && result_ready) && hold_req == 0);
      end
    end
  end

  task automatic send(utmpm_pkg::item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    expected_q.push_back(predict(it));
  endtask

  task automatic send_fields(logic [1:0] m, logic [3:0] r, logic [3:0] c, logic [29:0] v);
    utmpm_pkg::item_t it;
    it.mode = m;
    it.row = r;
    it.col = c;
    it.entry_value = v;
    send(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(bit [30:0] e, bit [4:0] d);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= utmpm_pkg::CFG_EXPONENT;
    cfg_data <= e;
    @(posedge clk);
    cfg_index <= utmpm_pkg::CFG_DIM;
    cfg_data <= {26'd0, d};
    @(posedge clk);
    cfg_we <= 1'b0;
    exp_reg = e;
    dim_reg = d;
  endtask

  task automatic test_reset_defaults();
    send_fields(utmpm_pkg::MODE_WRITE, 4'd0, 4'd15, 30'h3fffffff);
    send_fields(utmpm_pkg::MODE_WRITE, 4'd15, 4'd15, 30'd998244352);
    send_fields(utmpm_pkg::MODE_WRITE, 4'd15, 4'd0, 30'd12345);
    send_fields(utmpm_pkg::MODE_WRITE, 4'd0, 4'd0, 30'd0);
    send_fields(utmpm_pkg::MODE_WRITE, 4'd3, 4'd7, 30'd998244353);
    send_fields(utmpm_pkg::MODE_COMPUTE, 4'd0, 4'd0, 30'd0);
    send_fields(utmpm_pkg::MODE_READ, 4'd0, 4'd15, 30'd0);
    send_fields(utmpm_pkg::MODE_READ, 4'd15, 4'd15, 30'd0);
    send_fields(utmpm_pkg::MODE_READ, 4'd15, 4'd0, 30'd0);
    send_fields(utmpm_pkg::MODE_READ, 4'd3, 4'd7, 30'd0);
    send_fields(2'd3, 4'd15, 4'd15, 30'h3fffffff);
  endtask

  task automatic test_config_extremes();
    // exponent zero with dim zero, clamped to one
    set_config(31'd0, 5'd0);
    send_fields(utmpm_pkg::MODE_WRITE, 4'd0, 4'd1, 30'd7);
    send_fields(utmpm_pkg::MODE_COMPUTE, 4'd0, 4'd0, 30'd0);
    send_fields(utmpm_pkg::MODE_READ, 4'd0, 4'd0, 30'd0);
    send_fields(utmpm_pkg::MODE_READ, 4'd0, 4'd1, 30'd0);
    // largest exponent at full size
    set_config(31'h7fffffff, 5'd16);
    for (int i = 0; i < 4; i++)
      send_fields(utmpm_pkg::MODE_WRITE, 4'(i), 4'(i + 1), 30'($urandom));
    send_fields(utmpm_pkg::MODE_COMPUTE, 4'd0, 4'd0, 30'd0);
    send_fields(utmpm_pkg::MODE_READ, 4'd0, 4'd4, 30'd0);
    send_fields(utmpm_pkg::MODE_READ, 4'd15, 4'd15, 30'd0);
    // dim above range clamps, then shrink and enlarge
    set_config(31'd5, 5'd31);
    send_fields(utmpm_pkg::MODE_READ, 4'd2, 4'd3, 30'd0);
    set_config(31'd3, 5'd3);
    send_fields(utmpm_pkg::MODE_COMPUTE, 4'd0, 4'd0, 30'd0);
    send_fields(utmpm_pkg::MODE_READ, 4'd0, 4'd2, 30'd0);
    set_config(31'd3, 5'd16);
    send_fields(utmpm_pkg::MODE_READ, 4'd3, 4'd10, 30'd0);
  endtask

  task automatic test_random();
    int total;
    bit [4:0] d;
    bit [30:0] e;
    int nd;
    total = 0;
    while (total < 60) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) begin
        d = 5'($urandom_range(1, 6));
        e = 31'($urandom);
      end else begin
        d = 5'($urandom_range(0, 31));
        e = 31'($urandom_range(0, 63));
      end
      set_config(e, d);
      nd = (d == 0) ? 1 : (d > DIM ? DIM : d);
      for (int i = 0; i < 6; i++) begin
        int r;
        r = $urandom_range(0, nd - 1);
        send_fields(utmpm_pkg::MODE_WRITE, 4'(r), 4'($urandom_range(r, nd - 1)),
                    30'($urandom));
      end
      send_fields(utmpm_pkg::MODE_COMPUTE, 4'($urandom), 4'($urandom), 30'($urandom));
      for (int i = 0; i < 6; i++) begin
        int r;
        r = $urandom_range(0, nd - 1);
        send_fields(utmpm_pkg::MODE_READ, 4'(r), 4'($urandom_range(r, nd - 1)),
                    30'($urandom));
      end
      // noise
      for (int i = 0; i < 3; i++) begin
        utmpm_pkg::item_t it;
        it = 40'({$urandom, $urandom});
        if (it.mode == utmpm_pkg::MODE_COMPUTE) it.mode = utmpm_pkg::MODE_READ;
        send(it);
      end
      total += 16;
    end
    idle_on = 1;
  endtask

  task automatic test_backpressure();
    drain();
    idle_on = 0;
    hold_req = 300;
    for (int i = 0; i < 16; i++)
      send_fields((i % 2) ? utmpm_pkg::MODE_READ : utmpm_pkg::MODE_WRITE,
                  4'(i % 4), 4'(i % 8), 30'($urandom));
    idle_on = 1;
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    foreach (base_m[i]) base_m[i] = '0;
    foreach (power_m[i]) power_m[i] = '0;
    exp_reg = 31'd1;
    dim_reg = 5'd16;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_backpressure();
    test_random();

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d writes, %0d computes, %0d reads; %0d results checked",
             n_writes, n_computes, n_reads, n_results);
    $display("configs included exponent zero and maximum, dim zero, one, 16 and 31");
    if (errors == 0 && expected_q.size() == 0)
      $display("upper_triangular_matrix_power_mod_top regression: pass");
    else
      $display("upper_triangular_matrix_power_mod_top regression: fail");
    $finish;
  end

endmodule

// File: sim.f
hdl/utmpm_pkg.sv
hdl/upper_triangular_matrix_power_mod_top.sv
test/testbench.sv
